@@ src/uart_window_quality_scorer_core_defines.svh @@
// ============================================================================
// UART window quality scorer assertion macros
// Shared assertion forms for the scorer modules.
// ============================================================================
`ifndef UART_WINDOW_QUALITY_SCORER_CORE_DEFINES_SVH
`define UART_WINDOW_QUALITY_SCORER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UWQS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UWQS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/uwqs_pkg.sv @@
// ============================================================================
// UART window quality scorer package
// Shared constants, action codes, command and status types, and helpers.
// ============================================================================
package uwqs_pkg;

  // Width of the internal event counters.
  localparam int COUNT_WIDTH = 24;
  // Divider working width: a count times 100 fits in COUNT_WIDTH + 7 bits.
  localparam int DIV_WIDTH   = COUNT_WIDTH + 7;
  // Quotients of both divisions stay below 128.
  localparam int QUO_WIDTH   = 7;
  localparam int STEP_WIDTH  = 3;
  localparam logic [STEP_WIDTH-1:0] STEP_FIRST = STEP_WIDTH'(QUO_WIDTH - 1);

  // Weighted sum width (at most 10000) and reciprocal of 100.
  localparam int SUM_WIDTH   = 14;
  localparam int RECIP_WIDTH = 13;
  localparam int RECIP_SHIFT = 19;
  localparam logic [RECIP_WIDTH-1:0] RECIP_100 = 13'd5243;
  localparam int PROD_WIDTH  = SUM_WIDTH + RECIP_WIDTH;

  localparam logic [6:0] PCT_SCALE    = 7'd100;
  localparam logic [6:0] CLEAN_WEIGHT = 7'd60;
  localparam logic [6:0] TEXT_WEIGHT  = 7'd40;
  localparam logic [6:0] TEXT_BONUS_T = 7'd70;
  localparam logic [7:0] NL_BONUS     = 8'd5;
  localparam logic [7:0] SCORE_MAX    = 8'd100;

  // Input action codes.
  localparam logic [2:0] ACT_START   = 3'd0;
  localparam logic [2:0] ACT_BYTE    = 3'd1;
  localparam logic [2:0] ACT_LINE_ER = 3'd2;
  localparam logic [2:0] ACT_OVERRUN = 3'd3;
  localparam logic [2:0] ACT_CLOSE   = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic upd;
    logic div_ld_pct;
    logic div_ld_err;
    logic div_step;
    logic pct_save;
    logic sum_calc;
    logic score_calc;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;
    logic out_busy;
  } status_t;

  // Printable ASCII, tab, LF or CR.
  function automatic logic is_text(input logic [7:0] b);
    is_text = (b >= 8'h20 && b <= 8'h7E) || b == 8'h09 || b == 8'h0A || b == 8'h0D;
  endfunction

  // Saturate a counter to 16 bits.
  function automatic logic [15:0] sat16(input logic [COUNT_WIDTH-1:0] c);
    sat16 = (|c[COUNT_WIDTH-1:16]) ? 16'hFFFF : c[15:0];
  endfunction

endpackage

@@ src/uwqs_ctrl.sv @@
// ============================================================================
// UART window quality scorer controller
// Sequences counter updates, the two divisions, scoring and the report.
// ============================================================================
`include "uart_window_quality_scorer_core_defines.svh"

module uwqs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [2:0]       action_i,
  input  uwqs_pkg::status_t status_i,
  output uwqs_pkg::cmd_t   cmd_o
);
  import uwqs_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PCT    = 3'd1;
  localparam logic [2:0] S_ERR_LD = 3'd2;
  localparam logic [2:0] S_ERR    = 3'd3;
  localparam logic [2:0] S_SUM    = 3'd4;
  localparam logic [2:0] S_SCORE  = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0] state_q, state_d;
  logic       in_xact;

  // Items are taken only between reports.
  assign in_stall_o = (state_q != S_IDLE);
  assign in_xact    = in_valid_i && !in_stall_o;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_xact) begin
          if (action_i == ACT_CLOSE) begin
            cmd_o.div_ld_pct = 1'b1;
            state_d          = S_PCT;
          end else begin
            cmd_o.upd = 1'b1;
          end
        end
      end
      S_PCT: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_ERR_LD;
        end
      end
      S_ERR_LD: begin
        cmd_o.pct_save   = 1'b1;
        cmd_o.div_ld_err = 1'b1;
        state_d          = S_ERR;
      end
      S_ERR: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        cmd_o.sum_calc = 1'b1;
        state_d        = S_SCORE;
      end
      S_SCORE: begin
        cmd_o.score_calc = 1'b1;
        state_d          = S_OUT;
      end
      S_OUT: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `UWQS_ASSERT_NEXT(a_close_starts_div, clk_i, rst_ni,
    in_xact && action_i == ACT_CLOSE, state_q == S_PCT, "close did not start division")
  `UWQS_ASSERT_NEXT(a_err_div_to_sum, clk_i, rst_ni,
    state_q == S_ERR && status_i.div_last, state_q == S_SUM, "error division overran")
  `UWQS_ASSERT_NEXT(a_report_returns_idle, clk_i, rst_ni,
    state_q == S_OUT && !status_i.out_busy, state_q == S_IDLE, "report did not finish")

endmodule

@@ src/uwqs_datapath.sv @@
// ============================================================================
// UART window quality scorer datapath
// Window counters, shared restoring divider, score arithmetic, result register.
// ============================================================================
`include "uart_window_quality_scorer_core_defines.svh"

module uwqs_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  uwqs_pkg::cmd_t    cmd_i,
  output uwqs_pkg::status_t status_o,
  input  logic [2:0]        action_i,
  input  logic [7:0]        rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [15:0]       bytes_seen_o,
  output logic [15:0]       errors_seen_o,
  output logic [15:0]       overruns_seen_o,
  output logic [6:0]        text_percent_o,
  output logic [6:0]        quality_score_o
);
  import uwqs_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic [COUNT_WIDTH-1:0] byte_q, text_q, nl_q, err_q, ovr_q;
  logic [DIV_WIDTH-1:0]   rem_q, rem_d;
  logic [COUNT_WIDTH:0]   den_q, den_d;
  logic [QUO_WIDTH-1:0]   quo_q, quo_d;
  logic [STEP_WIDTH-1:0]  step_q, step_d;
  logic [DIV_WIDTH-1:0]   den_sh;
  logic [6:0]             pct_q;
  logic [SUM_WIDTH-1:0]   sum_q;
  logic [6:0]             score_q;
  logic [PROD_WIDTH-1:0]  prod;
  logic [7:0]             score_raw, score_bon;
  logic [6:0]             clean;
  logic                   out_valid_q;
  logic [15:0]            bytes_q, errors_q, ovrs_q;
  logic [6:0]             pct_out_q, score_out_q;
  logic                   win_empty;

  // Window counters, saturating at full scale.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
      text_q <= '0;
      nl_q   <= '0;
      err_q  <= '0;
      ovr_q  <= '0;
    end else if (cmd_i.upd) begin
      case (action_i)
        ACT_START: begin
          byte_q <= '0;
          text_q <= '0;
          nl_q   <= '0;
          err_q  <= '0;
          ovr_q  <= '0;
        end
        ACT_BYTE: begin
          if (byte_q != COUNT_MAX) begin
            byte_q <= byte_q + 1'b1;
          end
          if (is_text(rx_byte_i) && text_q != COUNT_MAX) begin
            text_q <= text_q + 1'b1;
          end
          if (rx_byte_i == 8'h0A && nl_q != COUNT_MAX) begin
            nl_q <= nl_q + 1'b1;
          end
        end
        ACT_LINE_ER: begin
          if (err_q != COUNT_MAX) begin
            err_q <= err_q + 1'b1;
          end
        end
        ACT_OVERRUN: begin
          if (ovr_q != COUNT_MAX) begin
            ovr_q <= ovr_q + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Restoring divider: one quotient bit per cycle, most significant first.
  assign den_sh = {{(DIV_WIDTH-COUNT_WIDTH-1){1'b0}}, den_q} << step_q;

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    step_d = step_q;
    if (cmd_i.div_ld_pct) begin
      rem_d  = {{(DIV_WIDTH-COUNT_WIDTH){1'b0}}, text_q} * DIV_WIDTH'(PCT_SCALE);
      den_d  = {1'b0, byte_q};
      quo_d  = '0;
      step_d = STEP_FIRST;
    end else if (cmd_i.div_ld_err) begin
      rem_d  = {{(DIV_WIDTH-COUNT_WIDTH){1'b0}}, err_q} * DIV_WIDTH'(PCT_SCALE);
      den_d  = {1'b0, byte_q} + {1'b0, err_q};
      quo_d  = '0;
      step_d = STEP_FIRST;
    end else if (cmd_i.div_step) begin
      if (rem_q >= den_sh) begin
        rem_d         = rem_q - den_sh;
        quo_d[step_q] = 1'b1;
      end
      step_d = step_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quo_q  <= quo_d;
    step_q <= step_d;
  end

  assign status_o.div_last = (step_q == '0);

  // Weighted blend of cleanliness and printability.
  assign clean = PCT_SCALE - quo_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pct_save) begin
      pct_q <= quo_q;
    end
    if (cmd_i.sum_calc) begin
      sum_q <= SUM_WIDTH'(clean) * SUM_WIDTH'(CLEAN_WEIGHT)
             + SUM_WIDTH'(pct_q) * SUM_WIDTH'(TEXT_WEIGHT);
    end
    if (cmd_i.score_calc) begin
      score_q <= (score_bon > SCORE_MAX) ? SCORE_MAX[6:0] : score_bon[6:0];
    end
  end

  // Divide the blend by 100 through a reciprocal, then add the newline bonus.
  assign prod      = PROD_WIDTH'(sum_q) * PROD_WIDTH'(RECIP_100);
  assign score_raw = prod[RECIP_SHIFT+7:RECIP_SHIFT];
  assign score_bon = (nl_q != '0 && pct_q > TEXT_BONUS_T) ? score_raw + NL_BONUS
                                                          : score_raw;

  assign win_empty = (byte_q == '0);

  // Result register; a held result waits while the sink stalls.
  assign status_o.out_busy = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      bytes_q     <= sat16(byte_q);
      errors_q    <= sat16(err_q);
      ovrs_q      <= sat16(ovr_q);
      pct_out_q   <= win_empty ? '0 : pct_q;
      score_out_q <= win_empty ? '0 : score_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign bytes_seen_o    = bytes_q;
  assign errors_seen_o   = errors_q;
  assign overruns_seen_o = ovrs_q;
  assign text_percent_o  = pct_out_q;
  assign quality_score_o = score_out_q;

  `UWQS_ASSERT_SAME(a_count_order, clk_i, rst_ni,
    1'b1, text_q <= byte_q && nl_q <= text_q, "text or newline count exceeds bytes")
  `UWQS_ASSERT_SAME(a_quotient_range, clk_i, rst_ni,
    cmd_i.sum_calc && !win_empty, quo_q <= PCT_SCALE && pct_q <= PCT_SCALE,
    "percentage out of range")
  `UWQS_ASSERT_NEXT(a_load_shows_result, clk_i, rst_ni,
    cmd_i.out_load, out_valid_q && score_out_q <= SCORE_MAX[6:0],
    "loaded result missing or out of range")

endmodule

@@ src/uart_window_quality_scorer_core.sv @@
// Operation: a start, byte, error or overrun transaction is absorbed into the counts.
// A close starts a report: two 7-step divisions on one shared restoring divider,
// a divisor load, a blend, a scaling step and the load of the result register.
// Throughput: 1 counting item per cycle while no report is in progress; a close holds off
// all new items until its report is loaded; that load waits while the output is stalled.
// Reset: all window counts clear to zero and no result is pending.
// ============================================================================
// UART window quality scorer core
// Counts UART receive events over a window and reports a quality score.
// ============================================================================
module uart_window_quality_scorer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] bytes_seen_o,
  output logic [15:0] errors_seen_o,
  output logic [15:0] overruns_seen_o,
  output logic [6:0]  text_percent_o,
  output logic [6:0]  quality_score_o
);
  import uwqs_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  uwqs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Counters, divider and result register.
  uwqs_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .action_i        (action_i),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .bytes_seen_o    (bytes_seen_o),
    .errors_seen_o   (errors_seen_o),
    .overruns_seen_o (overruns_seen_o),
    .text_percent_o  (text_percent_o),
    .quality_score_o (quality_score_o)
  );

endmodule

@@ tb/tb_uart_window_quality_scorer_core.sv @@
// ============================================================================
// UART window quality scorer core testbench
// Sends start, byte, line error, overrun and close transactions to the core.
// A predictor in the bench keeps its own window counts and works out the
// report for each close. The monitor compares every report with the oldest
// expected one. Both sides idle at random, and once the receiver holds off
// for a long time so that the core fills up and stalls its input.
// ============================================================================
module tb_uart_window_quality_scorer_core;
  import uwqs_pkg::*;

  // Action codes that the core ignores.
  localparam logic [2:0] ACT_RSVD_A = 3'd5;
  localparam logic [2:0] ACT_RSVD_B = 3'd6;
  localparam logic [2:0] ACT_RSVD_C = 3'd7;

  localparam int CNT_W          = COUNT_WIDTH;
  localparam int RANDOM_ITEMS   = 1125;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AFTER     = 8;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_SHOWN      = 10;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [15:0] bytes_seen;
    logic [15:0] errors_seen;
    logic [15:0] overruns_seen;
    logic [6:0]  text_percent;
    logic [6:0]  quality_score;
  } report_t;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic [2:0]  action    = ACT_START;
  logic [7:0]  rx_byte   = 8'h00;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  report_t     seen;

  uart_window_quality_scorer_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .action_i        (action),
    .rx_byte_i       (rx_byte),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .bytes_seen_o    (seen.bytes_seen),
    .errors_seen_o   (seen.errors_seen),
    .overruns_seen_o (seen.overruns_seen),
    .text_percent_o  (seen.text_percent),
    .quality_score_o (seen.quality_score)
  );

  // Pending transactions and the reports that the closes must produce.
  item_t   item_q[$];
  report_t report_q[$];

  // Window counts of the predictor.
  logic [CNT_W-1:0] byte_cnt    = '0;
  logic [CNT_W-1:0] text_cnt    = '0;
  logic [CNT_W-1:0] newline_cnt = '0;
  logic [CNT_W-1:0] error_cnt   = '0;
  logic [CNT_W-1:0] overrun_cnt = '0;

  int live_items      = 0;
  int items_taken     = 0;
  int reports_checked = 0;
  int mismatch_cnt    = 0;
  int peak_bytes      = 0;
  int scored_reports  = 0;
  logic item_taken    = 1'b0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Saturating increment of a window counter.
  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  function automatic logic [15:0] clip16(input logic [CNT_W-1:0] c);
    return (c > CNT_W'(16'hFFFF)) ? 16'hFFFF : c[15:0];
  endfunction

  // Printable ASCII plus tab, LF and CR count as text.
  function automatic bit counts_as_text(input logic [7:0] b);
    return (b >= 8'h20 && b <= 8'h7E) || b == 8'h09 || b == 8'h0A || b == 8'h0D;
  endfunction

  // Report of the current window: counts, text share and quality score.
  function automatic report_t score_window();
    report_t r;
    longint unsigned nb, nt, ne, pct, err_rate, clean, score;
    nb = byte_cnt;
    nt = text_cnt;
    ne = error_cnt;
    pct = 0;
    score = 0;
    if (nb != 0) begin
      err_rate = (ne * 100) / (nb + ne);
      pct = (nt * 100) / nb;
      if (pct > 100) pct = 100;
      if (err_rate > 100) err_rate = 100;
      clean = 100 - err_rate;
      // Cleanliness weighs 60 percent and printability 40 percent.
      score = (clean * 60 + pct * 40) / 100;
      if (newline_cnt != 0 && pct > 70) score += 5;
      if (score > 100) score = 100;
    end
    r.bytes_seen    = clip16(byte_cnt);
    r.errors_seen   = clip16(error_cnt);
    r.overruns_seen = clip16(overrun_cnt);
    r.text_percent  = pct[6:0];
    r.quality_score = score[6:0];
    return r;
  endfunction

  // Apply one accepted transaction to the predicted window.
  function automatic void absorb_item(input logic [2:0] act, input logic [7:0] b);
    case (act)
      ACT_START: begin
        byte_cnt    = '0;
        text_cnt    = '0;
        newline_cnt = '0;
        error_cnt   = '0;
        overrun_cnt = '0;
      end
      ACT_BYTE: begin
        byte_cnt = bump(byte_cnt);
        if (counts_as_text(b)) text_cnt = bump(text_cnt);
        if (b == 8'h0A) newline_cnt = bump(newline_cnt);
      end
      ACT_LINE_ER: error_cnt = bump(error_cnt);
      ACT_OVERRUN: overrun_cnt = bump(overrun_cnt);
      ACT_CLOSE: begin
        report_q.push_back(score_window());
        if (int'(byte_cnt) > peak_bytes) peak_bytes = int'(byte_cnt);
      end
      default: ;
    endcase
  endfunction

  function automatic void add_item(input logic [2:0] act, input logic [7:0] b);
    item_t it;
    it.action  = act;
    it.rx_byte = b;
    item_q.push_back(it);
    live_items++;
  endfunction

  // Byte content by window flavor: mostly text, binary, or a mix.
  function automatic logic [7:0] pick_byte(input int flavor);
    int r;
    r = $urandom_range(0, 99);
    if (flavor == 0) begin
      if (r < 80) return 8'($urandom_range(8'h20, 8'h7E));
      if (r < 90) return 8'h0A;
      if (r < 93) return 8'h0D;
      if (r < 95) return 8'h09;
      return 8'($urandom);
    end
    if (flavor == 2) return 8'($urandom);
    if (r < 45) return 8'($urandom_range(8'h20, 8'h7E));
    if (r < 55) return 8'h0A;
    return 8'($urandom);
  endfunction

  // One listening window with random content, or a stretch of noise.
  task automatic add_random_window();
    int flavor, len, k, r, err_share, ovr_share;
    flavor = $urandom_range(0, 4);
    if (flavor == 4) begin
      // Noise: arbitrary codes in arbitrary order, unused codes among them.
      len = $urandom_range(1, 10);
      for (k = 0; k < len; k++) add_item(3'($urandom_range(0, 7)), 8'($urandom));
      return;
    end
    err_share = (flavor == 0) ? 2 : (flavor == 1) ? 30 : 8;
    ovr_share = (flavor == 1) ? 10 : 4;
    if ($urandom_range(0, 9) != 0) add_item(ACT_START, 8'($urandom));
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 24);
    for (k = 0; k < len; k++) begin
      r = $urandom_range(0, 99);
      if (r < err_share) add_item(ACT_LINE_ER, 8'($urandom));
      else if (r < err_share + ovr_share) add_item(ACT_OVERRUN, 8'($urandom));
      else if (r < err_share + ovr_share + 2) add_item(3'($urandom_range(5, 7)), 8'($urandom));
      else add_item(ACT_BYTE, pick_byte(flavor));
    end
    add_item(ACT_CLOSE, 8'($urandom));
    // A close keeps the counts, so a second report follows the first.
    if ($urandom_range(0, 5) == 0) begin
      len = $urandom_range(0, 4);
      for (k = 0; k < len; k++) add_item(ACT_BYTE, pick_byte(flavor));
      add_item(ACT_CLOSE, 8'($urandom));
    end
  endtask

  // Driver: offers queued transactions in bursts with random gaps.
  int burst_left = 0;
  int gap_left   = 0;
  always @(negedge clk_i) begin
    item_t it;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || item_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (item_q.size() != 0) begin
        it = item_q.pop_front();
        in_valid <= 1'b1;
        action   <= it.action;
        rx_byte  <= it.rx_byte;
        if (burst_left == 0) burst_left = $urandom_range(1, 24);
        burst_left--;
        // A gap of random length, possibly zero, follows the last item of a burst.
        if (burst_left == 0) begin
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern of its own plus one long hold-off.
  int  hold_left  = 0;
  bit  hold_done  = 1'b0;
  bit  stall_on   = 1'b0;
  int  phase_left = 0;
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && reports_checked >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      if (phase_left == 0) begin
        stall_on = !stall_on;
        if (stall_on) phase_left = $urandom_range(1, 5);
        else phase_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
      end
      phase_left--;
      out_stall <= stall_on;
    end
  end

  // Monitor: predicts on every accepted transaction and checks every report.
  always @(posedge clk_i) begin
    report_t want;
    if (rst_ni) begin
      item_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        items_taken++;
        absorb_item(action, rx_byte);
      end
      if (out_valid && !out_stall) begin
        if (report_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_SHOWN)
            $display("ERROR: report with none expected: bytes %0d errors %0d overruns %0d",
                     seen.bytes_seen, seen.errors_seen, seen.overruns_seen);
        end else begin
          want = report_q.pop_front();
          reports_checked++;
          if (want.quality_score != 0) scored_reports++;
          if (seen.bytes_seen !== want.bytes_seen ||
              seen.errors_seen !== want.errors_seen ||
              seen.overruns_seen !== want.overruns_seen ||
              seen.text_percent !== want.text_percent ||
              seen.quality_score !== want.quality_score) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_SHOWN)
              $display({"ERROR: report %0d expected b=%0d e=%0d o=%0d pct=%0d q=%0d,",
                        " got b=%0d e=%0d o=%0d pct=%0d q=%0d"}, reports_checked,
                       want.bytes_seen, want.errors_seen, want.overruns_seen,
                       want.text_percent, want.quality_score,
                       seen.bytes_seen, seen.errors_seen, seen.overruns_seen,
                       seen.text_percent, seen.quality_score);
          end
        end
      end
    end
  end

  // Watchdog: ends the run after too many cycles without any transaction.
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("ERROR: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("uart_window_quality_scorer_core test failed");
        $finish;
      end
    end
  end

  initial begin
    int target;
    // Directed part: empty report after reset, byte class edges, ignored
    // codes, reports that keep counting, and the clamp of the score.
    add_item(ACT_CLOSE, 8'h00);
    add_item(ACT_START, 8'hFF);
    add_item(ACT_CLOSE, 8'h00);
    add_item(ACT_BYTE, 8'h00);
    add_item(ACT_BYTE, 8'hFF);
    add_item(ACT_BYTE, 8'h1F);
    add_item(ACT_BYTE, 8'h20);
    add_item(ACT_BYTE, 8'h7E);
    add_item(ACT_BYTE, 8'h7F);
    add_item(ACT_BYTE, 8'h09);
    add_item(ACT_BYTE, 8'h0A);
    add_item(ACT_BYTE, 8'h0D);
    add_item(ACT_LINE_ER, 8'h55);
    add_item(ACT_OVERRUN, 8'hAA);
    add_item(ACT_RSVD_A, 8'hAA);
    add_item(ACT_RSVD_B, 8'h55);
    add_item(ACT_RSVD_C, 8'hFF);
    add_item(ACT_CLOSE, 8'hFF);
    add_item(ACT_BYTE, 8'h41);
    add_item(ACT_CLOSE, 8'h00);
    add_item(ACT_START, 8'h00);
    add_item(ACT_BYTE, 8'h48);
    add_item(ACT_BYTE, 8'h69);
    add_item(ACT_BYTE, 8'h0A);
    add_item(ACT_CLOSE, 8'h00);
    add_item(ACT_START, 8'h00);
    add_item(ACT_LINE_ER, 8'h00);
    add_item(ACT_CLOSE, 8'h00);

    // Random windows.
    target = live_items + RANDOM_ITEMS;
    while (live_items < target) add_random_window();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (item_q.size() != 0 || in_valid) @(posedge clk_i);
    while (report_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d transactions and %0d window reports (%0d with a nonzero score).",
             items_taken, reports_checked, scored_reports);
    $display("Largest window held %0d bytes; %0d reports still outstanding at the end.",
             peak_bytes, report_q.size());
    if (mismatch_cnt == 0 && report_q.size() == 0) begin
      $display("uart_window_quality_scorer_core test passed");
    end else begin
      $display("Mismatches: %0d", mismatch_cnt);
      $display("uart_window_quality_scorer_core test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/uwqs_pkg.sv
src/uwqs_ctrl.sv
src/uwqs_datapath.sv
src/uart_window_quality_scorer_core.sv
tb/tb_uart_window_quality_scorer_core.sv
